/* design/tspf_pkg.sv */
// Shared types and constants for the transport-stream PID filter.
// No dependencies; used by every module of the block.
package tspf_pkg;

  localparam int PACKET_BYTES = 188;
  localparam int PID_SLOTS    = 6;

  localparam int BYTE_W   = 8;
  localparam int PID_W    = 13;
  localparam int CNT_W    = 3;
  localparam int POS_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PID_W;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_PID_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PID_BASE  = 3'd1;

  // Output queue
  localparam int BURST      = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [PID_W-1:0]     pid_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [PTR_W:0]       level_t;
  typedef logic [1:0]           push_n_t;

  typedef struct packed {
    logic  last;
    byte_t data;
  } out_t;

  // Up to three result beats written to the queue in one cycle, item[0] first
  typedef struct packed {
    push_n_t            n;
    out_t [BURST-1:0]   item;
  } push_t;

endpackage

/* design/tspf_cfg.sv */
// PID slot registers and the PID match logic.
// Depends on tspf_pkg.
module tspf_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  tspf_pkg::cfg_idx_t           cfg_index,
  input  logic [tspf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  tspf_pkg::pid_t               pid,
  output logic                         pid_pass
);

  tspf_pkg::cnt_t pid_count;
  tspf_pkg::pid_t pid_slot [tspf_pkg::PID_SLOTS];
  tspf_pkg::cnt_t enabled;
  tspf_pkg::cfg_idx_t slot_sel;

  assign slot_sel = cfg_index - tspf_pkg::REG_PID_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      pid_count <= '0;
      for (int k = 0; k < tspf_pkg::PID_SLOTS; k++) begin
        pid_slot[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == tspf_pkg::REG_PID_COUNT) begin
        pid_count <= cfg_data[tspf_pkg::CNT_W-1:0];
      end else if (cfg_index <= tspf_pkg::cfg_idx_t'(tspf_pkg::PID_SLOTS)) begin
        pid_slot[slot_sel] <= cfg_data[tspf_pkg::PID_W-1:0];
      end
    end
  end

  // counts above the slot total enable every slot
  always_comb begin
    if (pid_count > tspf_pkg::cnt_t'(tspf_pkg::PID_SLOTS)) begin
      enabled = tspf_pkg::cnt_t'(tspf_pkg::PID_SLOTS);
    end else begin
      enabled = pid_count;
    end
  end

  always_comb begin
    pid_pass = (pid_count == '0);
    for (int k = 0; k < tspf_pkg::PID_SLOTS; k++) begin
      if ((tspf_pkg::cnt_t'(k) < enabled) && (pid_slot[k] == pid)) begin
        pid_pass = 1'b1;
      end
    end
  end

endmodule

/* design/tspf_parse.sv */
// Input stage register, packet byte counter, header hold and pass decision.
// Depends on tspf_pkg; the match result comes from tspf_cfg.
module tspf_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  tspf_pkg::byte_t      s_tdata,   // [7:0] stream_byte
  input  tspf_pkg::level_t     q_level,
  output tspf_pkg::pid_t       pid,
  input  logic                 pid_pass,
  output tspf_pkg::push_t      push
);

  logic               in_valid;
  tspf_pkg::byte_t    in_byte;
  tspf_pkg::pos_t     pos;
  tspf_pkg::pos_t     pos_next;
  tspf_pkg::byte_t    hdr0;
  tspf_pkg::byte_t    hdr1;
  logic               pass_cur;
  logic               last;
  tspf_pkg::level_t   reserved;

  // room for what the staged beat will write, plus a full burst from the next one
  always_comb begin
    if (!in_valid) begin
      reserved = '0;
    end else if (pos == tspf_pkg::pos_t'(2)) begin
      reserved = tspf_pkg::level_t'(tspf_pkg::BURST);
    end else begin
      reserved = tspf_pkg::level_t'(1);
    end
  end

  assign s_tready = (q_level + reserved) <=
                    tspf_pkg::level_t'(tspf_pkg::FIFO_DEPTH - tspf_pkg::BURST);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_tvalid && s_tready;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  assign pid  = {hdr1[tspf_pkg::PID_W-tspf_pkg::BYTE_W-1:0], in_byte};
  assign last = (pos == tspf_pkg::pos_t'(tspf_pkg::PACKET_BYTES - 1));

  always_comb begin
    if (pos >= tspf_pkg::pos_t'(tspf_pkg::PACKET_BYTES - 1)) begin
      pos_next = '0;
    end else begin
      pos_next = pos + tspf_pkg::pos_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      hdr0     <= '0;
      hdr1     <= '0;
      pass_cur <= 1'b0;
    end else if (in_valid) begin
      pos <= pos_next;
      if (pos == tspf_pkg::pos_t'(0)) begin
        hdr0     <= in_byte;
        pass_cur <= 1'b0;
      end else if (pos == tspf_pkg::pos_t'(1)) begin
        hdr1 <= in_byte;
      end else if (pos == tspf_pkg::pos_t'(2)) begin
        pass_cur <= pid_pass;
      end
    end
  end

  always_comb begin
    push              = '0;
    push.item[0].data = in_byte;
    push.item[0].last = last;
    if (in_valid) begin
      if (pos == tspf_pkg::pos_t'(2)) begin
        push.item[0].data = hdr0;
        push.item[0].last = 1'b0;
        push.item[1].data = hdr1;
        push.item[1].last = 1'b0;
        push.item[2].data = in_byte;
        push.item[2].last = last;
        if (pid_pass) begin
          push.n = tspf_pkg::push_n_t'(tspf_pkg::BURST);
        end
      end else if (pos > tspf_pkg::pos_t'(2) && pass_cur) begin
        push.n = tspf_pkg::push_n_t'(1);
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < tspf_pkg::pos_t'(tspf_pkg::PACKET_BYTES))
    else $error("byte position out of packet range");

  a_pass_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && pos == tspf_pkg::pos_t'(0) |=> !pass_cur)
    else $error("pass flag not cleared at packet start");

endmodule

/* design/tspf_outq.sv */
// Output queue: takes up to three result beats a cycle.
// Gives one a cycle while m_tready is high. Depends on tspf_pkg.
module tspf_outq (
  input  logic               clk,
  input  logic               rst,
  input  tspf_pkg::push_t    push,
  output tspf_pkg::level_t   q_level,
  output logic               m_tvalid,
  input  logic               m_tready,
  output tspf_pkg::byte_t    m_tdata,   // [7:0] out_byte
  output logic               m_tlast    // packet_end
);

  tspf_pkg::out_t   mem [tspf_pkg::FIFO_DEPTH];
  tspf_pkg::ptr_t   wr_ptr;
  tspf_pkg::ptr_t   rd_ptr;
  tspf_pkg::level_t count;
  tspf_pkg::level_t count_next;
  tspf_pkg::out_t   head;
  logic             pop;

  assign pop      = (count != '0) && m_tready;
  assign m_tvalid = (count != '0);
  assign head     = mem[rd_ptr];
  assign m_tdata  = head.data;
  assign m_tlast  = head.last;
  assign q_level  = count;

  assign count_next = count + tspf_pkg::level_t'(push.n) - tspf_pkg::level_t'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < tspf_pkg::BURST; i++) begin
      if (tspf_pkg::push_n_t'(i) < push.n) begin
        mem[wr_ptr + tspf_pkg::ptr_t'(i)] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tspf_pkg::ptr_t'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + tspf_pkg::ptr_t'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != '0 |-> (count + tspf_pkg::level_t'(push.n)) <=
                     tspf_pkg::level_t'(tspf_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[tspf_pkg::PTR_W-1:0])
    else $error("queue pointers disagree with level");

endmodule

/* design/ts_packet_pid_filter.sv */
// Transport-stream PID filter, top level. An input beat passes through the stage
// register, then the eight-entry output queue, before the first output beat it causes.
// One input byte per cycle while s_tready is high; the queue keeps room for the staged
// beat and a header burst, so with the receiver always ready s_tready never drops.
// Reset: synchronous, active high; clears the byte counter, header, pass flag,
// PID registers and queue pointers.
module ts_packet_pid_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] stream_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] out_byte
  output logic                            m_tlast,   // packet_end
  input  logic                            cfg_we,
  input  logic [tspf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tspf_pkg::CFG_DATA_W-1:0] cfg_data
);

  tspf_pkg::pid_t   pid;
  logic             pid_pass;
  tspf_pkg::push_t  push;
  tspf_pkg::level_t q_level;

  tspf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pid       (pid),
    .pid_pass  (pid_pass)
  );

  tspf_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_level  (q_level),
    .pid      (pid),
    .pid_pass (pid_pass),
    .push     (push)
  );

  tspf_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .q_level  (q_level),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* sim/tb.sv */
// Self-checking bench for ts_packet_pid_filter: packet-aligned byte stream in,
// filtered bytes out, each beat compared with a local model of the PID filter.
// Depends on tspf_pkg and the RTL of the block; nothing else.
module tb;

  localparam int     DRAIN       = 6;
  localparam int     HOLD_CYCLES = 64;
  localparam int     STALL_LIMIT = 2000;
  localparam int     ITEMS       = 450;
  localparam tspf_pkg::pos_t   POS_LAST  = tspf_pkg::pos_t'(tspf_pkg::PACKET_BYTES - 1);
  localparam tspf_pkg::byte_t  SYNC      = 8'h47;
  localparam tspf_pkg::cfg_idx_t REG_SPARE =
    tspf_pkg::cfg_idx_t'(tspf_pkg::REG_PID_BASE + tspf_pkg::PID_SLOTS);
  localparam tspf_pkg::out_t   NONE      = '0;

  typedef enum logic [1:0] {DO_WRITE, DO_BYTE, DO_FILL} step_kind_t;

  typedef struct packed {
    step_kind_t                        kind;
    tspf_pkg::cfg_idx_t                idx;
    logic [tspf_pkg::CFG_DATA_W-1:0]   val;
    logic [7:0]                        reps;
    logic                              typed;
    logic [1:0]                        n;
    tspf_pkg::out_t [2:0]              res;
  } step_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [7:0]                      m_tdata;
  logic                            m_tlast;
  logic                            cfg_we;
  logic [tspf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tspf_pkg::CFG_DATA_W-1:0] cfg_data;

  ts_packet_pid_filter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local copy of the filter state and its registers
  tspf_pkg::pos_t  at_pos;
  tspf_pkg::byte_t hdr0, hdr1;
  logic            passing;
  tspf_pkg::cnt_t  enabled_cnt;
  tspf_pkg::pid_t  slot_pid [tspf_pkg::PID_SLOTS];
  tspf_pkg::pid_t  pkt_pid;

  tspf_pkg::out_t  due_beats [$];
  step_t           plan_q [$];

  int errors, bytes_in, packets, passed_pkts, beats_out, cfg_writes;
  int tx_calm, rx_calm, hold_asked, hold_done, quiet;

  task automatic flag(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic bit pid_admitted(input tspf_pkg::pid_t pid);
    int live;
    live = (enabled_cnt > tspf_pkg::PID_SLOTS) ? tspf_pkg::PID_SLOTS : enabled_cnt;
    if (enabled_cnt == 0) return 1'b1;
    for (int k = 0; k < live; k++)
      if (slot_pid[k] == pid) return 1'b1;
    return 1'b0;
  endfunction

  // one stream byte through the model; r[0] is the first beat out
  function automatic int sift_byte(input tspf_pkg::byte_t b,
                                   output tspf_pkg::out_t [2:0] r);
    logic fin;
    int   n;
    n   = 0;
    r   = '0;
    fin = (at_pos == POS_LAST);
    if (at_pos == 0) begin
      hdr0    = b;
      passing = 1'b0;
    end else if (at_pos == 1) begin
      hdr1 = b;
    end else if (at_pos == 2) begin
      passing = pid_admitted({hdr1[4:0], b});
      if (passing) begin
        r[0] = {1'b0, hdr0};
        r[1] = {1'b0, hdr1};
        r[2] = {fin, b};
        n    = 3;
      end
    end else if (passing) begin
      r[0] = {fin, b};
      n    = 1;
    end
    at_pos = fin ? tspf_pkg::pos_t'(0) : tspf_pkg::pos_t'(at_pos + 1);
    return n;
  endfunction

  // next byte of a packet whose first byte is usually the sync byte; the PID is picked there
  function automatic tspf_pkg::byte_t stream_byte_for();
    int live, r;
    live = (enabled_cnt > tspf_pkg::PID_SLOTS) ? tspf_pkg::PID_SLOTS : enabled_cnt;
    r    = $urandom_range(0, 99);
    case (at_pos)
      0: begin
        if (r < 40 && live > 0)
          pkt_pid = slot_pid[$urandom_range(0, live - 1)];
        else if (r < 55 && live < tspf_pkg::PID_SLOTS)
          pkt_pid = slot_pid[$urandom_range(live, tspf_pkg::PID_SLOTS - 1)];
        else if (r < 70 && live > 0)
          pkt_pid = slot_pid[$urandom_range(0, live - 1)] ^
                    (tspf_pkg::pid_t'(1) << $urandom_range(0, 12));
        else
          pkt_pid = tspf_pkg::pid_t'($urandom);
        return ($urandom_range(0, 4) != 0) ? SYNC : tspf_pkg::byte_t'($urandom);
      end
      1:       return {3'($urandom), pkt_pid[12:8]};
      2:       return pkt_pid[7:0];
      default: return tspf_pkg::byte_t'($urandom);
    endcase
  endfunction

  task automatic pick_gap(inout int calm, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (r < 2) begin
      calm = $urandom_range(40, 150);
      gap  = 0;
    end else if (r < 60) begin
      gap = 0;
    end else if (r < 88) begin
      gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 45);
    end
  endtask

  // register writes only once the block has gone quiet
  task automatic write_reg(input tspf_pkg::cfg_idx_t idx,
                           input logic [tspf_pkg::CFG_DATA_W-1:0] v);
    s_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tspf_pkg::REG_PID_COUNT)
      enabled_cnt = v[tspf_pkg::CNT_W-1:0];
    else if (idx >= tspf_pkg::REG_PID_BASE &&
             idx < tspf_pkg::REG_PID_BASE + tspf_pkg::PID_SLOTS)
      slot_pid[idx - tspf_pkg::REG_PID_BASE] = v[tspf_pkg::PID_W-1:0];
    cfg_writes++;
  endtask

  task automatic feed(input tspf_pkg::byte_t b, input bit typed, input int tn,
                      input tspf_pkg::out_t [2:0] tr);
    tspf_pkg::out_t [2:0] pr;
    int pn, g;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    if (at_pos == 0) packets++;
    pn = sift_byte(b, pr);
    if (pn == 3) passed_pkts++;
    if (typed) begin
      pn = tn;
      pr = tr;
    end
    for (int i = 0; i < pn; i++) due_beats.push_back(pr[i]);
    bytes_in++;
    pick_gap(tx_calm, g);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic void cfg_row(input tspf_pkg::cfg_idx_t i,
                                  input logic [tspf_pkg::CFG_DATA_W-1:0] v);
    step_t s;
    s       = '0;
    s.kind  = DO_WRITE;
    s.idx   = i;
    s.val   = v;
    plan_q.push_back(s);
  endfunction

  // reps above one: random filler, left to the model
  function automatic void byte_row(input tspf_pkg::byte_t b, input int reps, input int n,
                                   input tspf_pkg::out_t r0, input tspf_pkg::out_t r1,
                                   input tspf_pkg::out_t r2);
    step_t s;
    s        = '0;
    s.kind   = (reps > 1) ? DO_FILL : DO_BYTE;
    s.val    = {5'd0, b};
    s.reps   = reps[7:0];
    s.typed  = (reps == 1);
    s.n      = n[1:0];
    s.res[0] = r0;
    s.res[1] = r1;
    s.res[2] = r2;
    plan_q.push_back(s);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : sink
    int g;
    m_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_asked != hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        pick_gap(rx_calm, g);
        if (g == 0) begin
          m_tready <= 1'b1;
          @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_beats
    tspf_pkg::out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_beats.size() == 0) begin
        flag($sformatf("unexpected beat data %02h last %0b", m_tdata, m_tlast));
      end else begin
        want = due_beats.pop_front();
        if (m_tdata !== want.data)
          flag($sformatf("data %02h, want %02h", m_tdata, want.data));
        if (m_tlast !== want.last)
          flag($sformatf("last %0b on data %02h, want %0b", m_tlast, m_tdata, want.last));
        beats_out++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d beats outstanding",
                 quiet, due_beats.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    step_t                s;
    tspf_pkg::pid_t       plan_pid [tspf_pkg::PID_SLOTS];
    tspf_pkg::cnt_t       plan_cnt;
    int                   phase, len, r;

    s_tvalid = 1'b0;
    s_tdata  = '0;
    cfg_we   = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    at_pos = '0; hdr0 = '0; hdr1 = '0; passing = 1'b0;
    enabled_cnt = '0; pkt_pid = '0;
    foreach (slot_pid[k]) slot_pid[k] = '0;

    // count written with junk above bit 2 -> one slot; slot 0 at the top PID
    cfg_row(tspf_pkg::REG_PID_COUNT, 13'h1FF9);
    cfg_row(tspf_pkg::REG_PID_BASE, 13'h1FFF);
    cfg_row(REG_SPARE, 13'h0AAA);
    // PID 0 with the flag bits set: lives only in disabled slots, dropped
    byte_row(SYNC,  1, 0, NONE, NONE, NONE);
    byte_row(8'hE0, 1, 0, NONE, NONE, NONE);
    byte_row(8'h00, 1, 0, NONE, NONE, NONE);
    byte_row(8'h00, tspf_pkg::PACKET_BYTES - 3, 0, NONE, NONE, NONE);
    // PID 0x1FFF matches: header burst
    byte_row(SYNC,  1, 0, NONE, NONE, NONE);
    byte_row(8'h1F, 1, 0, NONE, NONE, NONE);
    byte_row(8'hFF, 1, 3, {1'b0, SYNC}, {1'b0, 8'h1F}, {1'b0, 8'hFF});
    byte_row(8'h00, 1, 1, {1'b0, 8'h00}, NONE, NONE);
    byte_row(8'hFF, 1, 1, {1'b0, 8'hFF}, NONE, NONE);
    // registers change mid-packet; the pass decision already taken must hold
    cfg_row(tspf_pkg::REG_PID_BASE, 13'h0000);
    cfg_row(tspf_pkg::REG_PID_COUNT, 13'h0002);
    byte_row(8'hA5, 1, 1, {1'b0, 8'hA5}, NONE, NONE);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    while (plan_q.size() != 0) begin
      s = plan_q.pop_front();
      case (s.kind)
        DO_WRITE: write_reg(s.idx, s.val);
        DO_BYTE:  feed(s.val[7:0], s.typed, s.n, s.res);
        DO_FILL:  repeat (s.reps) feed(tspf_pkg::byte_t'($urandom), s.typed, s.n, s.res);
        default:  ;
      endcase
    end

    phase = 0;
    while (bytes_in < ITEMS) begin
      foreach (plan_pid[k]) begin
        r = $urandom_range(0, 99);
        plan_pid[k] = (r < 15) ? tspf_pkg::pid_t'(0) :
                      (r < 30) ? tspf_pkg::pid_t'('1) : tspf_pkg::pid_t'($urandom);
      end
      case (phase)
        0: plan_cnt = '0;
        1: begin
          // above the slot count: all six slots live
          plan_cnt = tspf_pkg::cnt_t'(7);
          plan_pid[0] = '0;
          plan_pid[tspf_pkg::PID_SLOTS-1] = '1;
        end
        2: plan_cnt = tspf_pkg::cnt_t'(tspf_pkg::PID_SLOTS);
        3: begin
          plan_cnt = tspf_pkg::cnt_t'(1);
          plan_pid[0] = '1;
        end
        default: plan_cnt = tspf_pkg::cnt_t'($urandom_range(0, 7));
      endcase
      foreach (plan_pid[k])
        write_reg(tspf_pkg::cfg_idx_t'(tspf_pkg::REG_PID_BASE + k), plan_pid[k]);
      write_reg(tspf_pkg::REG_PID_COUNT, {10'($urandom), plan_cnt});
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 13'($urandom));
      if (phase == 0) begin
        // still inside a passing packet: receiver holds off, sender keeps offering
        hold_asked++;
        len     = 48;
        tx_calm = len;
      end else begin
        len = $urandom_range(16, 48);
      end
      if (len > ITEMS - bytes_in) len = ITEMS - bytes_in;
      repeat (len) feed(stream_byte_for(), 1'b0, 0, '0);
      phase++;
    end

    s_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (2 * DRAIN) @(posedge clk);

    $display("stream: %0d bytes, %0d packets (%0d passed), %0d beats checked",
             bytes_in, packets, passed_pkts, beats_out);
    $display("filter settings: %0d phases, %0d register writes", phase, cfg_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
